// File: design/sha1_byte_stream_hasher_defines.svh
// Assertion macros shared by the checker.
`ifndef SHA1_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define SBH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define SBH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/sha1_pkg.sv
`default_nettype none
package sha1_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  // One queued command between front and back.
  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_UPDATE, ST_PAD, ST_LEN, ST_EMIT
  } back_state_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) f = (b & c) | (~b & d);
    else if (r < 7'd40 || r >= 7'd60) f = b ^ c ^ d;
    else f = (b & c) | (b & d) | (c & d);
    return f;
  endfunction
endpackage
`default_nettype wire

// File: design/sha1_front.sv
`default_nettype none
// Two-entry command queue between the input port and the hashing engine.
module sha1_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sha1_pkg::cmd_t in_cmd,
  output logic               q_valid,
  input  wire logic          q_ready,
  output sha1_pkg::cmd_t     q_cmd
);
  import sha1_pkg::*;

  cmd_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_cmd;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: design/sha1_back.sv
`default_nettype none
// Hashing engine: block buffer in a 16-word shift line, one round per cycle.
module sha1_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire sha1_pkg::cmd_t q_cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [31:0]         digest_word,
  output logic [2:0]          word_index,
  output logic                status,
  output logic                last
);
  import sha1_pkg::*;

  back_state_t state, state_next;
  logic [31:0] w [16];
  logic [5:0]  byte_pos;
  logic [63:0] bit_len;
  logic        ovf;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  rnd;
  logic        finishing;
  logic        len_done;
  logic [2:0]  idx;
  logic        obad;

  logic [31:0] w_new, t_val;
  logic [64:0] len_sum;
  logic        absorb_go, finish_go, shift_byte;
  logic [7:0]  shift_val;

  assign w_new   = {w[13] ^ w[8] ^ w[2] ^ w[0]} << 1 | (w[13] ^ w[8] ^ w[2] ^ w[0]) >> 31;
  assign t_val   = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + w[0] + round_k(rnd);
  assign len_sum = {1'b0, bit_len} + 65'd8;

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    absorb_go  = 1'b0;
    finish_go  = 1'b0;
    shift_byte = 1'b0;
    shift_val  = q_cmd.data_byte;
    case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_cmd.func == FUNC_ABSORB) begin
            absorb_go  = 1'b1;
            shift_byte = !ovf;
            if (!ovf && byte_pos == 6'd63) state_next = ST_ROUND;
          end else begin
            finish_go = 1'b1;
            state_next = ovf ? ST_EMIT : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // Pad byte first, then zeros up to the length field.
        shift_byte = 1'b1;
        shift_val  = finishing ? 8'h00 : PAD_BYTE;
        if (byte_pos == 6'd63) state_next = ST_ROUND;
        else if (byte_pos == 6'd55 && !len_done) state_next = ST_LEN;
      end
      ST_LEN: begin
        shift_byte = 1'b1;
        shift_val  = bit_len[{3'd7 - byte_pos[2:0], 3'd0} +: 8];
        if (byte_pos == 6'd63) state_next = ST_ROUND;
      end
      ST_ROUND: if (rnd == 7'd79) state_next = ST_UPDATE;
      ST_UPDATE: state_next = !finishing ? ST_IDLE : (len_done ? ST_EMIT : ST_PAD);
      ST_EMIT: if (out_ready && idx == 3'd4) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid   = (state == ST_EMIT);
  assign digest_word = obad ? 32'd0 : h[idx];
  assign word_index  = idx;
  assign status      = obad;
  assign last        = (idx == 3'd4);

  always_ff @(posedge clk) begin
    if (shift_byte) begin
      for (int i = 0; i < 15; i++) w[i] <= (byte_pos[1:0] == 2'd0) ? w[i+1] : w[i];
      w[15] <= {w[15][23:0], shift_val};
    end
    if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t_val;
    end else begin
      a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
    end
    if (rst) begin
      state <= ST_IDLE;
      byte_pos <= 6'd0; bit_len <= 64'd0; ovf <= 1'b0;
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
      rnd <= 7'd0; finishing <= 1'b0; len_done <= 1'b0; idx <= 3'd0; obad <= 1'b0;
    end else begin
      state <= state_next;
      if (shift_byte) byte_pos <= byte_pos + 6'd1;
      if (absorb_go && !ovf) begin
        bit_len <= len_sum[63:0];
        if (len_sum[64]) ovf <= 1'b1;
      end
      if (finish_go) begin
        finishing <= 1'b0; len_done <= 1'b0; obad <= ovf; idx <= 3'd0;
      end
      if (state == ST_PAD && shift_val == PAD_BYTE) finishing <= 1'b1;
      if (state == ST_PAD && byte_pos == 6'd55 && !len_done) len_done <= 1'b1;
      if (state == ST_ROUND) rnd <= (rnd == 7'd79) ? 7'd0 : rnd + 7'd1;
      if (state == ST_UPDATE) begin
        h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
        h[3] <= h[3] + d; h[4] <= h[4] + e;
      end
      if (state == ST_EMIT && out_ready) begin
        idx <= idx + 3'd1;
        if (idx == 3'd4) begin
          byte_pos <= 6'd0; bit_len <= 64'd0; ovf <= 1'b0; finishing <= 1'b0;
          h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: design/sha1_byte_stream_hasher.sv
`default_nettype none
// Channel   Dir  tdata                      tuser
// s_axis    in   [7:0] data_byte            [0] func
// m_axis    out  [31:0] digest_word,        [0] status
//                [34:32] word_index
//                (tlast = last)
// The engine takes an absorb byte from the queue in its idle state; the 64th byte of
// a block then runs the rounds and the update on the shared round unit.
// A finish pads the block, appends the bit length and runs the rounds and updates
// (or goes straight to output when the length overflowed), then emits five beats.
// Reset is synchronous; a two-beat queue lets input continue while the engine
// runs rounds or the output stalls.
module sha1_byte_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic             m_axis_tuser,   // [0] status
  output logic             m_axis_tlast
);
  import sha1_pkg::*;

  cmd_t        in_cmd, q_cmd;
  logic        q_valid, q_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  assign in_cmd.func      = s_axis_tuser;
  assign in_cmd.data_byte = s_axis_tdata;

  sha1_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  sha1_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .digest_word, .word_index, .status(m_axis_tuser), .last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, word_index, digest_word};
endmodule
`default_nettype wire

// File: design/sha1_checker.sv
`default_nettype none
`include "sha1_byte_stream_hasher_defines.svh"
module sha1_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);
  `SBH_ASSERT_IMP(a_last_idx, clk, rst, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[34:32] == 3'd4), "tlast mismatch")
  `SBH_ASSERT_IMP(a_bad_zero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata[31:0] == 32'd0, "bad digest not zero")
  `SBH_ASSERT_NEXT(a_idx_step, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1, "index skip")
  `SBH_ASSERT_NEXT(a_stat_hold, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tuser == $past(m_axis_tuser), "status changed")
endmodule

bind sha1_byte_stream_hasher sha1_checker u_checker (.*);
`default_nettype wire
